FILE: rtl/core/odgm_pkg.sv
// Shared constants, types and lookup functions for the OLED dimming gain mapper.
// No dependencies; every other file of the block refers to it by scoped name.
package odgm_pkg;

    localparam int LEVEL_BITS   = 12;
    localparam int CFG_BITS     = 12;
    localparam int TABLE_LEN    = 66;
    localparam int TIDX_BITS    = $clog2(TABLE_LEN);
    localparam int QUO_BITS     = 7;
    localparam int DIV_W        = LEVEL_BITS + QUO_BITS;
    localparam int STEP_BITS    = $clog2(QUO_BITS);
    localparam int TAB_BITS     = 9;
    localparam int GAIN_BITS    = 16;
    localparam int DEPTH_BITS   = 4;
    localparam int GAIN_SHIFT   = 7;

    localparam int IN_TDATA_W   = ((LEVEL_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = LEVEL_BITS + 1 + GAIN_BITS + DEPTH_BITS + 1 + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [LEVEL_BITS-1:0] THRESHOLD_RESET = LEVEL_BITS'(66);
    localparam logic [QUO_BITS-1:0]   INDEX_SPAN      = QUO_BITS'(TABLE_LEN - 1);
    localparam logic [GAIN_BITS:0]    GAIN_MIN        = (GAIN_BITS+1)'(2560);
    localparam logic [GAIN_BITS:0]    GAIN_MAX        = (GAIN_BITS+1)'(32768);

    typedef enum logic {
        REG_DIMMING_ENABLE = 1'b0,
        REG_THRESHOLD      = 1'b1
    } t_reg_addr;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MAP  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    localparam logic [TAB_BITS-1:0] GAIN_TABLE [TABLE_LEN] = '{
        9'd42,  9'd56,  9'd67,  9'd75,  9'd84,  9'd91,  9'd98,  9'd104, 9'd109,
        9'd114, 9'd119, 9'd124, 9'd128, 9'd133, 9'd136, 9'd140, 9'd143, 9'd146,
        9'd150, 9'd152, 9'd156, 9'd159, 9'd162, 9'd165, 9'd168, 9'd172, 9'd176,
        9'd178, 9'd181, 9'd184, 9'd187, 9'd189, 9'd192, 9'd194, 9'd196, 9'd199,
        9'd202, 9'd204, 9'd206, 9'd209, 9'd211, 9'd213, 9'd215, 9'd217, 9'd220,
        9'd222, 9'd224, 9'd226, 9'd228, 9'd230, 9'd233, 9'd236, 9'd237, 9'd239,
        9'd241, 9'd241, 9'd243, 9'd245, 9'd246, 9'd249, 9'd249, 9'd250, 9'd252,
        9'd254, 9'd255, 9'd256
    };

    // Table entry times 128, held inside the legal gain window.
    function automatic logic [GAIN_BITS-1:0] gain_of(input logic [TIDX_BITS-1:0] tidx);
        logic [GAIN_BITS:0] g;
        g = (GAIN_BITS+1)'(GAIN_TABLE[tidx]) << GAIN_SHIFT;
        if (g < GAIN_MIN) begin
            g = GAIN_MIN;
        end
        if (g > GAIN_MAX) begin
            g = GAIN_MAX;
        end
        return g[GAIN_BITS-1:0];
    endfunction

    // Largest d in 1..8 with gain >= 128 << d, else 0.
    function automatic logic [DEPTH_BITS-1:0] depth_of(input logic [GAIN_BITS-1:0] g);
        logic [DEPTH_BITS-1:0] d;
        d = '0;
        for (int i = 1; i <= 8; i++) begin
            if ((g >> (GAIN_SHIFT + i)) != '0) begin
                d = DEPTH_BITS'(i);
            end
        end
        return d;
    endfunction

endpackage

FILE: rtl/core/odgm_div.sv
// Restoring divider: one compare-and-subtract per cycle, one quotient bit a step.
// Depends on odgm_pkg.
module odgm_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [odgm_pkg::DIV_W-1:0]       i_dividend,
    input  logic [odgm_pkg::LEVEL_BITS-1:0]  i_divisor,
    output logic                             o_done,
    output logic [odgm_pkg::QUO_BITS-1:0]    o_quotient
);

    logic [odgm_pkg::DIV_W-1:0]     r_rem;
    logic [odgm_pkg::DIV_W-1:0]     r_dsr;
    logic [odgm_pkg::QUO_BITS-1:0]  r_quo;
    logic [odgm_pkg::STEP_BITS-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic                           w_fit;

    assign w_fit = (r_rem >= r_dsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == odgm_pkg::STEP_BITS'(odgm_pkg::QUO_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dsr <= odgm_pkg::DIV_W'(i_divisor) << (odgm_pkg::QUO_BITS - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            // subtract the aligned divisor when it fits, then move one bit down
            if (w_fit) begin
                r_rem <= r_rem - r_dsr;
            end
            r_quo <= {r_quo[odgm_pkg::QUO_BITS-2:0], w_fit};
            r_dsr <= r_dsr >> 1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/core/odgm_gain.sv
// Gain lookup stage: table entry, gain clamp and dither depth, registered.
// Depends on odgm_pkg.
module odgm_gain (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic [odgm_pkg::TIDX_BITS-1:0]    i_tidx,
    output logic [odgm_pkg::GAIN_BITS-1:0]    o_gain,
    output logic [odgm_pkg::DEPTH_BITS-1:0]   o_depth
);

    logic [odgm_pkg::GAIN_BITS-1:0]  r_gain;
    logic [odgm_pkg::DEPTH_BITS-1:0] r_depth;
    logic [odgm_pkg::GAIN_BITS-1:0]  w_gain;

    assign w_gain = odgm_pkg::gain_of(i_tidx);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_gain  <= w_gain;
            r_depth <= odgm_pkg::depth_of(w_gain);
        end
    end

    assign o_gain  = r_gain;
    assign o_depth = r_depth;

endmodule

FILE: rtl/core/oled_dimming_gain_mapper_top.sv
// Path from an input transfer to m_axis_tvalid: 7 divider steps, the done handoff,
// the table lookup, then the output load.
// Items are taken one at a time, each only after the last has left the 7-step serial
// divider and the output load; a held result stalls the next item at its output load only.
// Reset (synchronous, active low): dimming off, threshold 66, correction inactive.
module oled_dimming_gain_mapper_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_addr,
    input  logic [odgm_pkg::CFG_BITS-1:0]       i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [11:0] level_in, upper bits zero
    input  logic [odgm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [11:0] level_out, [12] push_valid, [28:13] gain, [32:29] dither_depth,
    // [33] correction_on, [34] dither_on, upper bits zero
    output logic [odgm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int LB = odgm_pkg::LEVEL_BITS;

    odgm_pkg::t_state r_state, n_state;

    logic          r_en;
    logic [LB-1:0] r_thr;
    logic          r_corr_active;

    logic [LB-1:0] r_lvl_out;
    logic          r_push;
    logic          r_corr;
    logic          r_dith;
    logic          r_idx_one;

    logic                               r_m_valid;
    logic [odgm_pkg::OUT_TDATA_W-1:0]   r_m_data;

    logic                               w_accept;
    logic [LB-1:0]                      w_level;
    logic                               w_dim;
    logic [LB-1:0]                      w_v;
    logic [LB-1:0]                      w_vm1;
    logic [odgm_pkg::DIV_W-1:0]         w_dividend;
    logic [LB-1:0]                      w_divisor;
    logic                               w_div_done;
    logic [odgm_pkg::QUO_BITS-1:0]      w_quo;
    logic [odgm_pkg::TIDX_BITS-1:0]     w_tidx;
    logic [odgm_pkg::GAIN_BITS-1:0]     w_gain;
    logic [odgm_pkg::DEPTH_BITS-1:0]    w_depth;
    logic                               w_out_free;
    logic [odgm_pkg::OUT_FIELDS_W-1:0]  w_fields;

    assign s_axis_tready = (r_state == odgm_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_level       = s_axis_tdata[LB-1:0];
    assign w_dim         = r_en && (w_level < r_thr);
    assign w_v           = w_dim ? w_level : r_thr;
    assign w_vm1         = w_v - 1'b1;
    // (v - 1) * 65 as one shift and add
    assign w_dividend    = (odgm_pkg::DIV_W'(w_vm1) << 6) + odgm_pkg::DIV_W'(w_vm1);
    assign w_divisor     = r_thr - 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b0;
            r_thr <= odgm_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (odgm_pkg::t_reg_addr'(i_cfg_addr))
                odgm_pkg::REG_DIMMING_ENABLE: r_en  <= i_cfg_wdata[0];
                odgm_pkg::REG_THRESHOLD:      r_thr <= LB'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    odgm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // table index is quotient clamped to the last entry, or entry 0 on the special cases
    always_comb begin
        if (r_idx_one) begin
            w_tidx = '0;
        end else if (w_quo > odgm_pkg::INDEX_SPAN) begin
            w_tidx = odgm_pkg::TIDX_BITS'(odgm_pkg::INDEX_SPAN);
        end else begin
            w_tidx = odgm_pkg::TIDX_BITS'(w_quo);
        end
    end

    odgm_gain u_gain (
        .i_clk   (i_clk),
        .i_load  (r_state == odgm_pkg::ST_MAP),
        .i_tidx  (w_tidx),
        .o_gain  (w_gain),
        .o_depth (w_depth)
    );

    assign w_out_free = !r_m_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            odgm_pkg::ST_IDLE: if (w_accept)   n_state = odgm_pkg::ST_DIV;
            odgm_pkg::ST_DIV:  if (w_div_done) n_state = odgm_pkg::ST_MAP;
            odgm_pkg::ST_MAP:                  n_state = odgm_pkg::ST_OUT;
            odgm_pkg::ST_OUT:  if (w_out_free) n_state = odgm_pkg::ST_IDLE;
            default:                           n_state = odgm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= odgm_pkg::ST_IDLE;
            r_corr_active <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_corr_active <= w_dim;
            end
        end
    end

    // per-item payload, captured at the input transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lvl_out <= w_dim ? r_thr : w_level;
            r_push    <= w_dim || r_corr_active;
            r_corr    <= w_dim;
            r_dith    <= r_en;
            r_idx_one <= (w_v == '0) || (r_thr < LB'(2));
        end
    end

    assign w_fields = {
        r_push & r_dith,
        r_corr,
        r_push ? w_depth : '0,
        r_push ? w_gain  : '0,
        r_push,
        r_lvl_out
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == odgm_pkg::ST_OUT) && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == odgm_pkg::ST_OUT) && w_out_free) begin
            r_m_data <= odgm_pkg::OUT_TDATA_W'(w_fields);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
